// File: design/font_rom_glyph_fetcher_macros.svh
// ----------------------------------------------------------------------------
// Font ROM glyph fetcher assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FONT_ROM_GLYPH_FETCHER_MACROS_SVH
`define FONT_ROM_GLYPH_FETCHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRGF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRGF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/frgf_pkg.sv
// ----------------------------------------------------------------------------
// Font ROM glyph fetcher package
// Operation codes, register map, ROM command and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package frgf_pkg;

	localparam int ADDRESS_BITS_DEFAULT = 24;
	localparam int ASCII_BASE_W = 24;
	localparam logic [ASCII_BASE_W-1:0] ASCII_BASE_RESET = 24'h03B7C0;
	localparam logic [7:0] READ_CMD = 8'h03;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_ASCII_BASE = 1'b0;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_GLYPH  = 2'd1,
		OP_COLUMN = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		logic hanzi;
		logic unmapped;
	} map_info_t;

endpackage

`default_nettype wire

// File: design/frgf_map.sv
// ----------------------------------------------------------------------------
// Font ROM glyph address mapper
// Turns an ASCII code or a GB2312 row and cell pair into a glyph base address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frgf_map #(
	parameter int ADDRESS_BITS = frgf_pkg::ADDRESS_BITS_DEFAULT
) (
	input  wire logic [7:0]                            char_high,
	input  wire logic [7:0]                            char_low,
	input  wire logic [frgf_pkg::ASCII_BASE_W-1:0]     ascii_base,
	input  wire logic [ADDRESS_BITS-1:0]               prev_base,
	output logic      [ADDRESS_BITS-1:0]               glyph_base,
	output frgf_pkg::map_info_t                        info
);

	logic        is_ascii;
	logic        cell_ok;
	logic        row_a9;
	logic        row_a1;
	logic        row_b0;
	logic [6:0]  row_idx;
	logic [6:0]  cell_idx;
	logic [9:0]  row_add;
	logic [12:0] glyph_idx;
	logic [32:0] ascii_sum;
	logic [31:0] hanzi_base;

	always_comb begin
		is_ascii = (char_high >= 8'h20) && (char_high <= 8'h7E);
		cell_ok  = (char_low >= 8'hA1);
		row_a9   = (char_high == 8'hA9);
		row_a1   = (char_high >= 8'hA1) && (char_high <= 8'hA3);
		row_b0   = (char_high >= 8'hB0) && (char_high <= 8'hF7);
		cell_idx = 7'(char_low - 8'hA1);
		row_idx  = 7'd0;
		row_add  = 10'd0;
		if (row_a9) begin
			row_add = 10'd282;
		end else if (row_a1) begin
			row_idx = 7'(char_high - 8'hA1);
		end else begin
			row_idx = 7'(char_high - 8'hB0);
			row_add = 10'd846;
		end
		glyph_idx  = (13'(row_idx) * 13'd94) + 13'(cell_idx) + 13'(row_add);
		hanzi_base = 32'(glyph_idx) << 5;
		ascii_sum  = 33'(ascii_base) + (33'(char_high - 8'h20) << 4);

		info.hanzi    = !is_ascii;
		info.unmapped = 1'b0;
		if (is_ascii) begin
			glyph_base = ascii_sum[ADDRESS_BITS-1:0];
		end else if (cell_ok && (row_a9 || row_a1 || row_b0)) begin
			glyph_base = hanzi_base[ADDRESS_BITS-1:0];
		end else begin
			glyph_base    = prev_base;
			info.unmapped = 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: design/font_rom_glyph_fetcher.sv
// ----------------------------------------------------------------------------
// Font ROM glyph fetcher
// Serial-flash read sequencer for an 8x16 ASCII and 16x16 GB2312 font ROM.
// ----------------------------------------------------------------------------
// Input channel (in_valid, in_stall): each item is a bit tick, a whole glyph
// request or a single column request. A request latches the character and
// the glyph address; each later tick is one serial clock period that drives
// chip_select_n and mosi and samples miso. A read sends command 0x03, then
// ADDRESS_BITS address bits MSB first, then assembles data bytes MSB first.
// Output channel (out_valid, out_stall): one result item per input item.
// An item taken at one edge shows its result at the output register after that
// edge. One item is accepted every cycle while in_stall is low; the rate is
// set by the single state update between the input and the result register.
// in_stall is raised only while a held result is stalled, so the
// block keeps accepting items while the receiver takes each result.
// Reset empties the output register, returns the sequencer to idle and sets
// ascii_base to its default; no clearing pass is needed. The user must write
// ascii_base (APB address 0) only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module font_rom_glyph_fetcher #(
	parameter int ADDRESS_BITS = frgf_pkg::ADDRESS_BITS_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [frgf_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [frgf_pkg::PDATA_W-1:0]    pwdata,
	output logic      [frgf_pkg::PDATA_W-1:0]    prdata,
	output logic                                 pready,

	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      operation,
	input  wire logic [7:0]                      char_high,
	input  wire logic [7:0]                      char_low,
	input  wire logic [3:0]                      column,
	input  wire logic                            miso,

	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 chip_select_n,
	output logic                                 mosi,
	output logic      [7:0]                      data_byte,
	output logic                                 byte_valid,
	output logic                                 last_byte,
	output logic                                 is_hanzi,
	output logic                                 code_unmapped,
	output logic                                 busy_res
);

	localparam int CW = $clog2(ADDRESS_BITS);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CMD,
		PH_ADDR,
		PH_DATA,
		PH_GAP
	} phase_t;

	phase_t                                phase_q, phase_d;
	logic [CW-1:0]                         bit_cnt_q, bit_cnt_d;
	logic [ADDRESS_BITS-1:0]               fetch_addr_q, fetch_addr_d;
	logic [7:0]                            shift_q, shift_d;
	logic [5:0]                            bytes_left_q, bytes_left_d;
	logic                                  second_pend_q, second_pend_d;
	logic                                  hanzi_q, hanzi_d;
	logic                                  unmapped_q, unmapped_d;
	logic [ADDRESS_BITS-1:0]               glyph_base_q, glyph_base_d;
	logic [frgf_pkg::ASCII_BASE_W-1:0]     ascii_base_q;

	logic                                  out_valid_q;
	logic                                  cs_n_q, mosi_q, byte_valid_q, last_q;
	logic                                  hanzi_out_q, unmapped_out_q, busy_q;
	logic [7:0]                            data_q;

	logic                                  take;
	logic                                  cfg_write;
	logic [ADDRESS_BITS-1:0]               map_base;
	frgf_pkg::map_info_t                   map_info;
	frgf_pkg::op_t                         op;
	logic                                  cs_n_d, mosi_d, byte_valid_d, last_d;
	logic [7:0]                            data_d;
	logic [CW-1:0]                         cnt_inc;
	logic [CW-1:0]                         addr_idx;
	logic [5:0]                            bytes_dec;
	logic                                  link_active;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == frgf_pkg::REG_ASCII_BASE) ?
		frgf_pkg::PDATA_W'(ascii_base_q) : '0;

	assign in_stall = out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;
	assign op       = frgf_pkg::op_t'(operation);

	frgf_map #(
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_map (
		.char_high (char_high),
		.char_low  (char_low),
		.ascii_base(ascii_base_q),
		.prev_base (glyph_base_q),
		.glyph_base(map_base),
		.info      (map_info)
	);

	always_comb begin
		phase_d       = phase_q;
		bit_cnt_d     = bit_cnt_q;
		fetch_addr_d  = fetch_addr_q;
		shift_d       = shift_q;
		bytes_left_d  = bytes_left_q;
		second_pend_d = second_pend_q;
		hanzi_d       = hanzi_q;
		unmapped_d    = unmapped_q;
		glyph_base_d  = glyph_base_q;
		cs_n_d        = 1'b1;
		mosi_d        = 1'b0;
		data_d        = 8'd0;
		byte_valid_d  = 1'b0;
		last_d        = 1'b0;
		cnt_inc       = bit_cnt_q + 1'b1;
		addr_idx      = CW'(ADDRESS_BITS - 1) - bit_cnt_q;
		bytes_dec     = (bytes_left_q != 6'd0) ? bytes_left_q - 6'd1 : 6'd0;
		link_active   = (phase_q == PH_CMD) || (phase_q == PH_ADDR) ||
			(phase_q == PH_DATA);

		case (op)
			frgf_pkg::OP_GLYPH, frgf_pkg::OP_COLUMN: begin
				if (phase_q == PH_IDLE) begin
					hanzi_d      = map_info.hanzi;
					unmapped_d   = map_info.unmapped;
					glyph_base_d = map_base;
					phase_d      = PH_CMD;
					bit_cnt_d    = '0;
					shift_d      = 8'd0;
					if (op == frgf_pkg::OP_GLYPH) begin
						fetch_addr_d  = map_base;
						bytes_left_d  = map_info.hanzi ? 6'd32 : 6'd16;
						second_pend_d = 1'b0;
					end else begin
						fetch_addr_d  = map_base + ADDRESS_BITS'(column);
						bytes_left_d  = 6'd1;
						second_pend_d = 1'b1;
					end
				end else begin
					cs_n_d = !link_active;
				end
			end
			frgf_pkg::OP_TICK: begin
				case (phase_q)
					PH_IDLE: begin
					end
					PH_CMD: begin
						cs_n_d    = 1'b0;
						mosi_d    = frgf_pkg::READ_CMD[3'd7 - bit_cnt_q[2:0]];
						bit_cnt_d = cnt_inc;
						if (bit_cnt_q == CW'(7)) begin
							phase_d   = PH_ADDR;
							bit_cnt_d = '0;
						end
					end
					PH_ADDR: begin
						cs_n_d    = 1'b0;
						mosi_d    = fetch_addr_q[addr_idx];
						bit_cnt_d = cnt_inc;
						if (bit_cnt_q == CW'(ADDRESS_BITS - 1)) begin
							phase_d   = PH_DATA;
							bit_cnt_d = '0;
							shift_d   = 8'd0;
						end
					end
					PH_DATA: begin
						cs_n_d    = 1'b0;
						shift_d   = {shift_q[6:0], miso};
						bit_cnt_d = cnt_inc;
						if (bit_cnt_q == CW'(7)) begin
							bit_cnt_d    = '0;
							byte_valid_d = 1'b1;
							data_d       = {shift_q[6:0], miso};
							shift_d      = 8'd0;
							bytes_left_d = bytes_dec;
							if (bytes_dec == 6'd0) begin
								if (second_pend_q) begin
									second_pend_d = 1'b0;
									fetch_addr_d  = fetch_addr_q +
										(hanzi_q ? ADDRESS_BITS'(16) : ADDRESS_BITS'(8));
									phase_d       = PH_GAP;
								end else begin
									last_d  = 1'b1;
									phase_d = PH_IDLE;
								end
							end
						end
					end
					PH_GAP: begin
						phase_d      = PH_CMD;
						bit_cnt_d    = '0;
						bytes_left_d = 6'd1;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
			default: begin
				cs_n_d = !link_active;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_base_q <= frgf_pkg::ASCII_BASE_RESET;
		end else if (cfg_write && (paddr[2] == frgf_pkg::REG_ASCII_BASE)) begin
			ascii_base_q <= pwdata[frgf_pkg::ASCII_BASE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_cnt_q     <= '0;
			fetch_addr_q  <= '0;
			shift_q       <= 8'd0;
			bytes_left_q  <= 6'd0;
			second_pend_q <= 1'b0;
			hanzi_q       <= 1'b0;
			unmapped_q    <= 1'b0;
			glyph_base_q  <= '0;
		end else if (take) begin
			phase_q       <= phase_d;
			bit_cnt_q     <= bit_cnt_d;
			fetch_addr_q  <= fetch_addr_d;
			shift_q       <= shift_d;
			bytes_left_q  <= bytes_left_d;
			second_pend_q <= second_pend_d;
			hanzi_q       <= hanzi_d;
			unmapped_q    <= unmapped_d;
			glyph_base_q  <= glyph_base_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cs_n_q         <= cs_n_d;
			mosi_q         <= mosi_d;
			data_q         <= data_d;
			byte_valid_q   <= byte_valid_d;
			last_q         <= last_d;
			hanzi_out_q    <= hanzi_d;
			unmapped_out_q <= unmapped_d;
			busy_q         <= (phase_d != PH_IDLE);
		end
	end

	assign out_valid     = out_valid_q;
	assign chip_select_n = cs_n_q;
	assign mosi          = mosi_q;
	assign data_byte     = data_q;
	assign byte_valid    = byte_valid_q;
	assign last_byte     = last_q;
	assign is_hanzi      = hanzi_out_q;
	assign code_unmapped = unmapped_out_q;
	assign busy_res      = busy_q;

endmodule

`default_nettype wire

// File: design/frgf_checker.sv
// ----------------------------------------------------------------------------
// Font ROM glyph fetcher port checker
// Watches the top-level ports and checks the serial read framing over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "font_rom_glyph_fetcher_macros.svh"

module frgf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       chip_select_n,
	input wire logic       mosi,
	input wire logic [7:0] data_byte,
	input wire logic       byte_valid,
	input wire logic       last_byte,
	input wire logic       busy_res
);

	`FRGF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data_byte) && $stable(chip_select_n), "stalled result item changed")
	`FRGF_ASSERT_IMP(a_stall_source, in_stall, out_valid && out_stall, "input stalled without a held result item")
	`FRGF_ASSERT_IMP(a_byte_cs, out_valid && byte_valid, !chip_select_n, "data byte outside chip select")
	`FRGF_ASSERT_IMP(a_mosi_cs, out_valid && mosi, !chip_select_n, "mosi driven with chip select high")
	`FRGF_ASSERT_IMP(a_last_done, out_valid && last_byte, byte_valid && !busy_res, "last byte without completed read")

endmodule

bind font_rom_glyph_fetcher frgf_checker u_frgf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.chip_select_n(chip_select_n),
	.mosi         (mosi),
	.data_byte    (data_byte),
	.byte_valid   (byte_valid),
	.last_byte    (last_byte),
	.busy_res     (busy_res)
);

`default_nettype wire

// File: tb/tb_font_rom_glyph_fetcher.sv
// ----------------------------------------------------------------------------
// Font ROM glyph fetcher testbench
// Drives glyph and column requests followed by the bit ticks that complete
// each serial read, predicts chip select, mosi and the assembled bytes per
// item, and compares every result item against the prediction. The run
// changes ascii_base between phases, with bursty input and a stalling
// receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_font_rom_glyph_fetcher;

	localparam int ADDR_W = frgf_pkg::ADDRESS_BITS_DEFAULT;
	localparam int PA_W = frgf_pkg::PADDR_W;
	localparam int PD_W = frgf_pkg::PDATA_W;
	localparam int AB_W = frgf_pkg::ASCII_BASE_W;
	localparam logic [PA_W-1:0] ASCII_ADDR = PA_W'(4 * frgf_pkg::REG_ASCII_BASE);

	typedef enum int {SEQ_IDLE, SEQ_CMD, SEQ_ADDR, SEQ_DATA, SEQ_GAP} seq_phase_t;

	typedef struct packed {
		frgf_pkg::op_t op;
		logic [7:0]    ch;
		logic [7:0]    cl;
		logic [3:0]    col;
		logic          miso;
	} fetch_item_t;

	typedef struct packed {
		logic       cs_n;
		logic       mosi;
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic       hanzi;
		logic       unmapped;
		logic       busy;
	} pin_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PA_W-1:0] paddr = '0;
	logic [PD_W-1:0] pwdata = '0;
	logic [PD_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = '0;
	logic [7:0] char_high = '0;
	logic [7:0] char_low = '0;
	logic [3:0] column = '0;
	logic miso = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic chip_select_n;
	logic mosi;
	logic [7:0] data_byte;
	logic byte_valid;
	logic last_byte;
	logic is_hanzi;
	logic code_unmapped;
	logic busy_res;

	font_rom_glyph_fetcher #(.ADDRESS_BITS(ADDR_W)) DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.char_high(char_high), .char_low(char_low), .column(column), .miso(miso),
		.out_valid(out_valid), .out_stall(out_stall), .chip_select_n(chip_select_n),
		.mosi(mosi), .data_byte(data_byte), .byte_valid(byte_valid),
		.last_byte(last_byte), .is_hanzi(is_hanzi), .code_unmapped(code_unmapped),
		.busy_res(busy_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

	// Sequencer shadow state.
	logic [AB_W-1:0] ascii_cfg = frgf_pkg::ASCII_BASE_RESET;
	seq_phase_t seq_phase = SEQ_IDLE;
	int bit_cnt = 0;
	logic [ADDR_W-1:0] fetch_addr = '0;
	logic [ADDR_W-1:0] glyph_base = '0;
	logic [7:0] shift_reg = '0;
	int bytes_left = 0;
	int second_offset = 0;
	logic second_pending = 1'b0;
	logic hanzi_q = 1'b0;
	logic unmapped_q = 1'b0;

	fetch_item_t pending_fetch_items[$];
	pin_result_t expected_pins[$];
	fetch_item_t cur_item = '0;
	int issued_cnt = 0;
	int accepted_cnt = 0;
	int err_cnt = 0;
	int burst_left = 0;
	int gap_left = 0;

	task automatic latch_glyph(input logic [7:0] h, input logic [7:0] l);
		if (h >= 8'h20 && h <= 8'h7E) begin
			hanzi_q = 1'b0;
			unmapped_q = 1'b0;
			glyph_base = ADDR_W'(int'(ascii_cfg) + (int'(h) - 'h20) * 16);
		end else begin
			hanzi_q = 1'b1;
			unmapped_q = 1'b0;
			if (h == 8'hA9 && l >= 8'hA1)
				glyph_base = ADDR_W'((282 + int'(l) - 'hA1) * 32);
			else if (h >= 8'hA1 && h <= 8'hA3 && l >= 8'hA1)
				glyph_base = ADDR_W'(((int'(h) - 'hA1) * 94 + int'(l) - 'hA1) * 32);
			else if (h >= 8'hB0 && h <= 8'hF7 && l >= 8'hA1)
				glyph_base = ADDR_W'(((int'(h) - 'hB0) * 94 + int'(l) - 'hA1 + 846) * 32);
			else
				unmapped_q = 1'b1;
		end
	endtask

	task automatic advance_sequencer(input fetch_item_t it, output pin_result_t r);
		r = '0;
		r.cs_n = 1'b1;
		if (it.op != frgf_pkg::OP_TICK) begin
			if (it.op != frgf_pkg::OP_NOP && seq_phase == SEQ_IDLE) begin
				latch_glyph(it.ch, it.cl);
				seq_phase = SEQ_CMD;
				bit_cnt = 0;
				shift_reg = '0;
				if (it.op == frgf_pkg::OP_GLYPH) begin
					fetch_addr = glyph_base;
					bytes_left = hanzi_q ? 32 : 16;
					second_pending = 1'b0;
				end else begin
					fetch_addr = glyph_base + ADDR_W'(it.col);
					second_offset = hanzi_q ? 16 : 8;
					bytes_left = 1;
					second_pending = 1'b1;
				end
			end else if (seq_phase == SEQ_CMD || seq_phase == SEQ_ADDR ||
					seq_phase == SEQ_DATA) begin
				r.cs_n = 1'b0;
			end
		end else begin
			case (seq_phase)
				SEQ_CMD: begin
					r.cs_n = 1'b0;
					r.mosi = frgf_pkg::READ_CMD[7 - bit_cnt];
					bit_cnt++;
					if (bit_cnt >= 8) begin
						seq_phase = SEQ_ADDR;
						bit_cnt = 0;
					end
				end
				SEQ_ADDR: begin
					r.cs_n = 1'b0;
					r.mosi = fetch_addr[ADDR_W - 1 - bit_cnt];
					bit_cnt++;
					if (bit_cnt >= ADDR_W) begin
						seq_phase = SEQ_DATA;
						bit_cnt = 0;
						shift_reg = '0;
					end
				end
				SEQ_DATA: begin
					r.cs_n = 1'b0;
					shift_reg = {shift_reg[6:0], it.miso};
					bit_cnt++;
					if (bit_cnt >= 8) begin
						bit_cnt = 0;
						r.valid = 1'b1;
						r.data = shift_reg;
						shift_reg = '0;
						if (bytes_left > 0)
							bytes_left--;
						if (bytes_left == 0) begin
							if (second_pending) begin
								second_pending = 1'b0;
								fetch_addr = fetch_addr + ADDR_W'(second_offset);
								seq_phase = SEQ_GAP;
							end else begin
								r.last = 1'b1;
								seq_phase = SEQ_IDLE;
							end
						end
					end
				end
				SEQ_GAP: begin
					seq_phase = SEQ_CMD;
					bit_cnt = 0;
					bytes_left = 1;
				end
				default: seq_phase = SEQ_IDLE;
			endcase
		end
		r.hanzi = hanzi_q;
		r.unmapped = unmapped_q;
		r.busy = (seq_phase != SEQ_IDLE);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp,
			input logic [31:0] act);
		if (act !== exp) begin
			err_cnt++;
			$display("%0t ns: %s expected %0h actual %0h", $time, name, exp, act);
		end
	endtask

	// Sender: bursts of items with random gaps between them.
	always @(posedge clk) begin
		fetch_item_t nxt;
		pin_result_t predicted;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				advance_sequencer(cur_item, predicted);
				expected_pins.push_back(predicted);
				accepted_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_fetch_items.size() > 0) begin
					nxt = pending_fetch_items.pop_front();
					cur_item = nxt;
					operation <= nxt.op;
					char_high <= nxt.ch;
					char_low <= nxt.cl;
					column <= nxt.col;
					miso <= nxt.miso;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(7) == 0) ? $urandom_range(150, 400)
							: $urandom_range(1, 40);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall density changes from stretch to stretch, plus long holds.
	always @(posedge clk) begin
		int cyc_cnt;
		int hold_left;
		int mode_left;
		int stall_pct;
		if (arst_n) begin
			cyc_cnt++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (cyc_cnt == 700 || cyc_cnt == 4000) begin
				hold_left = 90;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					case ($urandom_range(4))
						0, 1: stall_pct = 0;
						2: stall_pct = 25;
						3: stall_pct = 60;
						default: stall_pct = 85;
					endcase
					mode_left = $urandom_range(20, 150);
				end
				mode_left--;
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		pin_result_t exp;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pins.size() == 0) begin
				err_cnt++;
				$display("%0t ns: result item with no expected item pending", $time);
			end else begin
				exp = expected_pins.pop_front();
				check_field("chip_select_n", exp.cs_n, chip_select_n);
				check_field("mosi", exp.mosi, mosi);
				check_field("data_byte", exp.data, data_byte);
				check_field("byte_valid", exp.valid, byte_valid);
				check_field("last_byte", exp.last, last_byte);
				check_field("is_hanzi", exp.hanzi, is_hanzi);
				check_field("code_unmapped", exp.unmapped, code_unmapped);
				check_field("busy_res", exp.busy, busy_res);
			end
		end
	end

	function automatic fetch_item_t random_item(input frgf_pkg::op_t op);
		fetch_item_t it;
		it.op = op;
		it.ch = 8'($urandom);
		it.cl = 8'($urandom);
		it.col = 4'($urandom);
		it.miso = 1'($urandom);
		return it;
	endfunction

	task automatic queue_item(input fetch_item_t it);
		pending_fetch_items.push_back(it);
		issued_cnt++;
	endtask

	// A request followed by exactly the ticks that finish its reads; noise_pct
	// sprinkles ignored requests and no-ops between the ticks.
	task automatic queue_fetch(input frgf_pkg::op_t op, input logic [7:0] h,
			input logic [7:0] l, input logic [3:0] col, input int noise_pct);
		fetch_item_t it;
		int ticks;
		it = random_item(op);
		it.ch = h;
		it.cl = l;
		it.col = col;
		queue_item(it);
		if (op == frgf_pkg::OP_GLYPH)
			ticks = 8 + ADDR_W + 8 * ((h >= 8'h20 && h <= 8'h7E) ? 16 : 32);
		else
			ticks = 2 * (8 + ADDR_W + 8) + 1;
		repeat (ticks) begin
			if ($urandom_range(99) < noise_pct)
				queue_item(random_item(frgf_pkg::op_t'($urandom_range(1, 3))));
			queue_item(random_item(frgf_pkg::OP_TICK));
		end
	endtask

	task automatic queue_random_fetches(input int target);
		int start;
		logic [7:0] h;
		logic [7:0] l;
		int noise_pct;
		start = issued_cnt;
		while (issued_cnt - start < target) begin
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(1, 4))
					queue_item(random_item(($urandom_range(1) == 0) ?
						frgf_pkg::OP_TICK : frgf_pkg::OP_NOP));
			l = 8'($urandom_range('hA1, 'hFF));
			case ($urandom_range(9))
				0, 1, 2: begin
					h = 8'($urandom_range('h20, 'h7E));
					l = 8'($urandom);
				end
				3: h = 8'($urandom_range('hA1, 'hA3));
				4: h = 8'hA9;
				5, 6, 7: h = 8'($urandom_range('hB0, 'hF7));
				default: begin
					h = 8'($urandom);
					l = 8'($urandom);
				end
			endcase
			case ($urandom_range(2))
				0: noise_pct = 0;
				1: noise_pct = 5;
				default: noise_pct = 20;
			endcase
			queue_fetch(($urandom_range(6) == 0) ? frgf_pkg::OP_GLYPH : frgf_pkg::OP_COLUMN,
				h, l, 4'($urandom), noise_pct);
		end
	endtask

	task automatic wait_drained();
		while (accepted_cnt != issued_cnt || expected_pins.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic read_ascii_base();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ASCII_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("ascii_base", ascii_cfg, prdata[AB_W-1:0]);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_ascii_base(input logic [AB_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ASCII_ADDR;
		pwdata <= PD_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ascii_cfg = value;
		read_ascii_base();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		read_ascii_base();

		// Ticks and a no-op while idle, then an unmapped pair right after reset,
		// which reads from address zero.
		queue_item(random_item(frgf_pkg::OP_TICK));
		queue_item(random_item(frgf_pkg::OP_TICK));
		queue_item(random_item(frgf_pkg::OP_NOP));
		queue_fetch(frgf_pkg::OP_COLUMN, 8'h00, 8'h00, 4'd0, 0);
		queue_fetch(frgf_pkg::OP_GLYPH, 8'h20, 8'hFF, 4'd15, 0);
		queue_fetch(frgf_pkg::OP_COLUMN, 8'hA9, 8'hFF, 4'd8, 0);
		queue_fetch(frgf_pkg::OP_COLUMN, 8'hF7, 8'hFF, 4'd15, 0);
		queue_fetch(frgf_pkg::OP_COLUMN, 8'hA1, 8'hA0, 4'd2, 0);
		queue_fetch(frgf_pkg::OP_GLYPH, 8'hA3, 8'hFF, 4'd0, 10);
		wait_drained();

		write_ascii_base(24'hFFFFFF);
		queue_fetch(frgf_pkg::OP_COLUMN, 8'h7E, 8'hAA, 4'd15, 0);
		queue_random_fetches(80);
		wait_drained();

		write_ascii_base(AB_W'($urandom));
		queue_random_fetches(80);
		wait_drained();

		repeat (5) @(posedge clk);
		if (err_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
